FILE: src/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg: shared types and constants for the PGN movetext tokenizer
// Character codes, scanner state encodings and the helpers that classify
// movetext bytes and match result tokens one character at a time.
// ----------------------------------------------------------------------------
package pmt_pkg;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'b001,
      MODE_BRACE  = 3'b010,
      MODE_LINE   = 3'b100
   } scan_mode_type;

   // Progress through a leading digits-and-dots prefix of the open token.
   typedef enum logic [2:0] {
      PH_DIGITS = 3'b001,
      PH_DOTS   = 3'b010,
      PH_MOVE   = 3'b100
   } prefix_type;

   // Back end hands a token bank back to the front end.
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_TWO    = 8'h32;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // Bit positions in the result-token match mask.
   localparam int RES_STAR  = 0;
   localparam int RES_WHITE = 1;
   localparam int RES_BLACK = 2;
   localparam int RES_DRAW  = 3;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // Which result tokens ("*", "1-0", "0-1", "1/2-1/2") carry c at pos.
   function automatic logic [3:0] result_match(input logic [6:0] pos,
                                               input logic [7:0] c);
      logic [3:0] m;
      m = '0;
      unique case (pos)
         7'd0: begin
            m[RES_STAR]  = (c == CH_STAR);
            m[RES_WHITE] = (c == CH_ONE);
            m[RES_BLACK] = (c == CH_ZERO);
            m[RES_DRAW]  = (c == CH_ONE);
         end
         7'd1: begin
            m[RES_WHITE] = (c == CH_DASH);
            m[RES_BLACK] = (c == CH_DASH);
            m[RES_DRAW]  = (c == CH_SLASH);
         end
         7'd2: begin
            m[RES_WHITE] = (c == CH_ZERO);
            m[RES_BLACK] = (c == CH_ONE);
            m[RES_DRAW]  = (c == CH_TWO);
         end
         7'd3: m[RES_DRAW] = (c == CH_DASH);
         7'd4: m[RES_DRAW] = (c == CH_ONE);
         7'd5: m[RES_DRAW] = (c == CH_SLASH);
         7'd6: m[RES_DRAW] = (c == CH_TWO);
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

FILE: src/pgn_movetext_tokenizer_core.sv
// ----------------------------------------------------------------------------
// pgn_movetext_tokenizer_core: PGN movetext SAN tokenizer
// Cuts PGN movetext into SAN move tokens and streams them out character by
// character, skipping comments, variations, glyphs, results and move numbers.
// ----------------------------------------------------------------------------
// Usage. Movetext enters on the req_ channel, one byte per transaction, with
// req_tlast on the final byte of a game's movetext. Move tokens leave on the
// rsp_ channel, one character per transaction; rsp_tlast marks the final
// character of a token and rsp_tuser[0] is set on every character of a token
// that was longer than MAX_TOKEN_CHARS and was truncated.
// Throughput: the scanner takes one byte per cycle. Characters are written
// into one of two token banks in RAM; a finished token is handed to the
// emitter through a two-entry descriptor queue, and the scanner stalls
// (req_tready low) only while both banks still hold tokens not yet read out.
// The emitter reads one character per cycle from the RAM read port while the
// output buffer has room or a character is leaving it.
// Path: with the emitter idle, once the delimiter (or final byte) is accepted,
// the token passes the descriptor queue, the emitter address registers, the
// registered RAM read and the output buffer before rsp_tvalid rises.
// Stalls: a low rsp_tready holds the two-entry output buffer; the emitter
// stops reading, then the banks fill and the scanner back-pressures req_.
// Reset: synchronous and active high; it returns the scanner to normal
// scanning at depth zero and empties the queue and buffers. The token RAM
// needs no clearing, as only characters written for the current token are read.
// ----------------------------------------------------------------------------
module pgn_movetext_tokenizer_core
   import pmt_pkg::*;
#(
   parameter int MAX_TOKEN_CHARS = 32,
   parameter int DEPTH_BITS      = 8
) (
   input  logic       clock,
   input  logic       reset,
   // Movetext input
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,   // text_last
   // Token characters out
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] san_char
   output logic       rsp_tlast,   // token_last
   output logic [0:0] rsp_tuser    // [0] token_overflow
);

   localparam int PTR_W  = $clog2(MAX_TOKEN_CHARS);
   localparam int ADDR_W = PTR_W + 1;
   localparam int DESC_W = 2 * PTR_W + 2;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              q_push;
   logic [DESC_W-1:0] q_push_data;
   logic              q_pop;
   logic [DESC_W-1:0] q_pop_data;
   logic              q_valid;
   logic              q_full;
   release_type       bank_release;

   // Scanner: classifies bytes, fills token banks, judges finished tokens.
   pmt_front #(
      .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
      .DEPTH_BITS      (DEPTH_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .bank_release (bank_release),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .push         (q_push),
      .push_data    (q_push_data)
   );

   // Two token banks of MAX_TOKEN_CHARS characters each.
   pmt_ram #(
      .WIDTH (8),
      .DEPTH (2 ** ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Descriptors of tokens that survived and await emission.
   pmt_queue #(
      .WIDTH (DESC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .valid     (q_valid),
      .full      (q_full)
   );

   // Emitter: reads token characters back and drives the result channel.
   pmt_back #(
      .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_pop_data),
      .q_pop        (q_pop),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .bank_release (bank_release),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

   // The bank accounting must keep the queue from ever overflowing.
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_full))
      else $error("token descriptor pushed into a full queue");

   // The emitter may only take a descriptor that is present.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("descriptor popped from an empty queue");

   // A token is only handed over while a byte is being accepted.
   assert property (@(posedge clock) disable iff (reset)
                    q_push |-> (req_tvalid && req_tready))
      else $error("token descriptor pushed without an accepted byte");

   // A bank is never written in the cycle the emitter reads the same address.
   assert property (@(posedge clock) disable iff (reset)
                    !(wr_en && rd_en && (wr_addr == rd_addr)))
      else $error("token bank written while being read out");

endmodule

FILE: src/pmt_ram.sv
// ----------------------------------------------------------------------------
// pmt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pmt_queue.sv
// ----------------------------------------------------------------------------
// pmt_queue: two-entry descriptor queue
// Holds finished token descriptors between the scanner and the emitter.
// ----------------------------------------------------------------------------
module pmt_queue #(
   parameter int WIDTH = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             valid,
   output logic             full
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, wp_in;
   logic             rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rp_ff];
   assign valid    = (cnt_ff != 2'd0);
   assign full     = cnt_ff[1];

endmodule

FILE: src/pmt_front.sv
// ----------------------------------------------------------------------------
// pmt_front: movetext scanner
// Accepts movetext bytes, tracks comments and variation depth, writes token
// characters into the current bank and judges each token as it finishes.
// ----------------------------------------------------------------------------
module pmt_front
   import pmt_pkg::*;
#(
   parameter int MAX_TOKEN_CHARS = 32,
   parameter int DEPTH_BITS      = 8,
   localparam int PTR_W  = $clog2(MAX_TOKEN_CHARS),
   localparam int ADDR_W = PTR_W + 1,
   localparam int DESC_W = 2 * PTR_W + 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  release_type       bank_release,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data,
   output logic              push,
   output logic [DESC_W-1:0] push_data
);

   localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);

   scan_mode_type         mode_ff, mode_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [LEN_W-1:0]      len_ff, len_in, len_n;
   logic                  ovf_ff, ovf_in, ovf_n;
   logic                  dollar_ff, dollar_in, dollar_n;
   logic [3:0]            match_ff, match_in, match_n;
   prefix_type            phase_ff, phase_in, phase_n;
   logic [PTR_W-1:0]      start_ff, start_in, start_n;
   logic                  bank_ff, bank_in;
   logic [1:0]            busy_ff, busy_in;

   logic       accept;
   logic       delim;
   logic       finish;
   logic       is_result;
   logic       emit;
   logic [7:0] c;

   assign c          = req_tdata;
   assign req_tready = !busy_ff[bank_ff];
   assign accept     = req_tvalid && req_tready;
   assign delim      = is_space(c) || (c == CH_LBRACE) || (c == CH_LPAREN) ||
                       (c == CH_RPAREN) || (c == CH_SEMI);

   always_comb begin
      mode_in  = mode_ff;
      depth_in = depth_ff;
      len_n    = len_ff;
      ovf_n    = ovf_ff;
      dollar_n = dollar_ff;
      match_n  = match_ff;
      phase_n  = phase_ff;
      start_n  = start_ff;
      finish   = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = {bank_ff, len_ff[PTR_W-1:0]};
      wr_data  = c;

      if (accept) begin
         unique case (mode_ff)
            MODE_BRACE: begin
               if (c == CH_RBRACE) mode_in = MODE_NORMAL;
            end
            MODE_LINE: begin
               if (c == CH_NL) mode_in = MODE_NORMAL;
            end
            MODE_NORMAL: begin
               if (delim) begin
                  finish = 1'b1;
                  if (c == CH_LBRACE) begin
                     mode_in = MODE_BRACE;
                  end else if (c == CH_SEMI) begin
                     mode_in = MODE_LINE;
                  end else if (c == CH_LPAREN) begin
                     if (depth_ff != '1) depth_in = depth_ff + 1'b1;
                  end else if (c == CH_RPAREN) begin
                     if (depth_ff != '0) depth_in = depth_ff - 1'b1;
                  end
               end else if (len_ff < LEN_W'(MAX_TOKEN_CHARS)) begin
                  wr_en   = 1'b1;
                  len_n   = len_ff + 1'b1;
                  match_n = match_ff & result_match(7'(len_ff), c);
                  if (len_ff == '0) dollar_n = (c == CH_DOLLAR);
                  unique case (phase_ff)
                     PH_DIGITS: begin
                        if (c == CH_DOT) begin
                           phase_n = PH_DOTS;
                        end else if (!is_digit(c)) begin
                           phase_n = PH_MOVE;
                           start_n = '0;
                        end
                     end
                     PH_DOTS: begin
                        if (c != CH_DOT) begin
                           phase_n = PH_MOVE;
                           start_n = len_ff[PTR_W-1:0];
                        end
                     end
                     PH_MOVE: phase_n = PH_MOVE;
                     default: phase_n = PH_MOVE;
                  endcase
               end else begin
                  ovf_n = 1'b1;
               end
            end
            default: mode_in = MODE_NORMAL;
         endcase
         if (req_tlast) begin
            finish   = 1'b1;
            mode_in  = MODE_NORMAL;
            depth_in = '0;
         end
      end
   end

   // Result tokens only count when nothing was truncated.
   assign is_result = !ovf_n &&
                      ((match_n[RES_STAR]  && (len_n == LEN_W'(1))) ||
                       (match_n[RES_WHITE] && (len_n == LEN_W'(3))) ||
                       (match_n[RES_BLACK] && (len_n == LEN_W'(3))) ||
                       (match_n[RES_DRAW]  && (len_n == LEN_W'(7))));

   // Judged at the depth before this byte acts on it.
   assign emit = finish && (len_n != '0) && (depth_ff == '0) && !dollar_n &&
                 !is_result && (phase_n == PH_MOVE);

   assign push      = emit;
   assign push_data = {ovf_n, PTR_W'(len_n - 1'b1), start_n, bank_ff};

   always_comb begin
      if (finish) begin
         len_in    = '0;
         ovf_in    = 1'b0;
         dollar_in = 1'b0;
         match_in  = '1;
         phase_in  = PH_DIGITS;
         start_in  = '0;
      end else begin
         len_in    = len_n;
         ovf_in    = ovf_n;
         dollar_in = dollar_n;
         match_in  = match_n;
         phase_in  = phase_n;
         start_in  = start_n;
      end
      bank_in = bank_ff ^ emit;
      busy_in = busy_ff;
      if (bank_release.valid) busy_in[bank_release.bank] = 1'b0;
      if (emit) busy_in[bank_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         depth_ff  <= '0;
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
         dollar_ff <= 1'b0;
         match_ff  <= '1;
         phase_ff  <= PH_DIGITS;
         start_ff  <= '0;
         bank_ff   <= 1'b0;
         busy_ff   <= 2'b00;
      end else begin
         mode_ff   <= mode_in;
         depth_ff  <= depth_in;
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
         dollar_ff <= dollar_in;
         match_ff  <= match_in;
         phase_ff  <= phase_in;
         start_ff  <= start_in;
         bank_ff   <= bank_in;
         busy_ff   <= busy_in;
      end
   end

endmodule

FILE: src/pmt_back.sv
// ----------------------------------------------------------------------------
// pmt_back: token emitter
// Takes token descriptors from the queue, reads the characters out of the
// token RAM and presents them through a two-entry output buffer.
// ----------------------------------------------------------------------------
module pmt_back
   import pmt_pkg::*;
#(
   parameter int MAX_TOKEN_CHARS = 32,
   localparam int PTR_W  = $clog2(MAX_TOKEN_CHARS),
   localparam int ADDR_W = PTR_W + 1,
   localparam int DESC_W = 2 * PTR_W + 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  logic [DESC_W-1:0] q_data,
   output logic              q_pop,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output release_type       bank_release,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic [0:0]        rsp_tuser
);

   logic             act_ff, act_in;
   logic             bank_ff, bank_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] end_ff, end_in;
   logic             ovf_ff, ovf_in;
   logic             s1_v_ff;
   logic             s1_last_ff;
   logic             s1_ovf_ff;
   logic [9:0]       ob_ff [2];
   logic             wr_ff, rd_ff;
   logic [1:0]       cnt_ff, cnt_in;

   logic       pop;
   logic [1:0] occ;
   logic       issue;
   logic       at_end;

   assign pop    = rsp_tvalid && rsp_tready;
   assign occ    = cnt_ff + 2'(s1_v_ff);
   assign issue  = act_ff && ((occ < 2'd2) || pop);
   assign at_end = (ptr_ff == end_ff);
   assign q_pop  = q_valid && (!act_ff || (issue && at_end));

   assign rd_en   = issue;
   assign rd_addr = {bank_ff, ptr_ff};

   assign bank_release.valid = issue && at_end;
   assign bank_release.bank  = bank_ff;

   always_comb begin
      act_in  = act_ff;
      bank_in = bank_ff;
      ptr_in  = ptr_ff;
      end_in  = end_ff;
      ovf_in  = ovf_ff;
      if (issue) begin
         ptr_in = ptr_ff + 1'b1;
         if (at_end) act_in = 1'b0;
      end
      if (q_pop) begin
         act_in                   = 1'b1;
         {ovf_in, end_in, ptr_in, bank_in} = q_data;
      end
      cnt_in = cnt_ff + 2'(s1_v_ff) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         s1_v_ff <= 1'b0;
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         act_ff  <= act_in;
         s1_v_ff <= issue;
         wr_ff   <= wr_ff ^ s1_v_ff;
         rd_ff   <= rd_ff ^ pop;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff    <= bank_in;
      ptr_ff     <= ptr_in;
      end_ff     <= end_in;
      ovf_ff     <= ovf_in;
      s1_last_ff <= at_end;
      s1_ovf_ff  <= ovf_ff;
      if (s1_v_ff) begin
         ob_ff[wr_ff] <= {s1_ovf_ff, s1_last_ff, rd_data};
      end
   end

   assign rsp_tvalid   = (cnt_ff != 2'd0);
   assign rsp_tdata    = ob_ff[rd_ff][7:0];
   assign rsp_tlast    = ob_ff[rd_ff][8];
   assign rsp_tuser[0] = ob_ff[rd_ff][9];

endmodule
